@@ hdl/nearest_centroid_assign_defines.svh @@
// Assertion macros shared by the checker of the nearest-centroid block.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef NEAREST_CENTROID_ASSIGN_DEFINES_SVH
`define NEAREST_CENTROID_ASSIGN_DEFINES_SVH

// Same-cycle implication.
`define NCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/nca_pkg.sv @@
// Shared constants, codes and beat types of the nearest-centroid block.
// Used by every module of the block but nca_ram; depends on nothing.
package nca_pkg;

    localparam int MAX_CLUSTERS = 64;
    localparam int MAX_DIM      = 256;
    localparam int VALUE_BITS   = 16;

    localparam int CL_W   = $clog2(MAX_CLUSTERS);
    localparam int EL_W   = $clog2(MAX_DIM);
    localparam int NCL_W  = 7;
    localparam int DIST_W = 48;
    localparam int POP_W  = 24;
    localparam int PN_W   = 32;
    localparam int SQ_W   = 2 * VALUE_BITS + 1;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 112;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [POP_W-1:0]  POP_MAX  = {POP_W{1'b1}};
    localparam logic [NCL_W-1:0]  NUM_CLUSTERS_RESET = NCL_W'(MAX_CLUSTERS);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } nca_op_t;

    // One beat travelling down the row of cells, with the running minimum.
    typedef struct packed {
        logic                         valid;
        nca_op_t                      op;
        logic [CL_W-1:0]              cl;
        logic [EL_W-1:0]              el;
        logic signed [VALUE_BITS-1:0] val;
        logic                         last;
        logic [CL_W-1:0]              best_idx;
        logic [DIST_W-1:0]            best_dist;
    } nca_beat_t;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [POP_W-1:0]  cluster_population;
        logic [PN_W-1:0]   point_number;
        logic [DIST_W-1:0] min_distance;
        logic [CL_W-1:0]   best_cluster;
    } nca_result_t;

endpackage

@@ hdl/nearest_centroid_assign.sv @@
// Nearest-centroid assignment by squared Euclidean distance.
// Input beats (s_*): tuser selects a centroid load or a point element, tlast
// marks the final element of a point. Each load writes one component into
// the cell of its cluster; each point element is added to the distance
// accumulator of every cluster in use as it passes down a row of 64 cells.
// A point's last element gives one result beat (m_*) with the winning
// cluster, its distance, the point's sequence number and the new population.
// One beat is taken per cycle while s_tready is high. Each cell holds three
// pipeline stages (centroid read, square, accumulate and compare); the
// tally stage and the output register follow the row.
// Reset clears the accumulators, populations, point counter and pipeline;
// centroids must be loaded before use and num_clusters returns to 64.
// When the receiver stalls, one further result is caught in a skid register;
// once that is full the whole row halts and s_tready falls until the
// waiting result is taken. Write num_clusters only while the row is empty;
// the block does not enforce this. Depends on nca_pkg, nca_cell and nca_tally.
module nearest_centroid_assign (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [nca_pkg::NCL_W-1:0]       cfg_wr_data,  // num_clusters
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cluster_index [5:0], elem_index [13:6], elem_value [29:14], zero fill
    input  logic [nca_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                      s_tuser,      // op
    input  logic                            s_tlast,      // last_element
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // best_cluster [5:0], min_distance [53:6], point_number [85:54],
    // cluster_population [109:86], zero fill
    output logic [nca_pkg::M_TDATA_W-1:0]   m_tdata
);
    import nca_pkg::*;

    logic [NCL_W-1:0]        num_clusters_reg;
    logic [NCL_W-1:0]        n_eff;
    logic [MAX_CLUSTERS-1:0] in_use;
    logic                    enable;
    nca_beat_t               chain [MAX_CLUSTERS+1];
    logic                    res_valid;
    nca_result_t             res;
    logic                    push;
    logic                    m_valid_reg;
    nca_result_t             m_data_reg;
    logic                    skid_valid_reg;
    nca_result_t             skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_clusters_reg <= NUM_CLUSTERS_RESET;
        end else if (cfg_wr_en) begin
            num_clusters_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (num_clusters_reg == '0) begin
            n_eff = NCL_W'(1);
        end else if (num_clusters_reg > NCL_W'(MAX_CLUSTERS)) begin
            n_eff = NCL_W'(MAX_CLUSTERS);
        end else begin
            n_eff = num_clusters_reg;
        end
    end

    assign enable   = !skid_valid_reg;
    assign s_tready = enable;

    always_comb begin
        chain[0].valid     = s_tvalid && enable;
        chain[0].op        = nca_op_t'(s_tuser[0]);
        chain[0].cl        = s_tdata[CL_W-1:0];
        chain[0].el        = s_tdata[CL_W +: EL_W];
        chain[0].val       = s_tdata[CL_W+EL_W +: VALUE_BITS];
        chain[0].last      = s_tlast;
        chain[0].best_idx  = '0;
        chain[0].best_dist = DIST_MAX;
    end

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        assign in_use[g] = NCL_W'(g) < n_eff;

        nca_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .enable  (enable),
            .in_use  (in_use[g]),
            .cell_id (CL_W'(g)),
            .beat_in (chain[g]),
            .beat_out(chain[g+1])
        );
    end

    nca_tally u_tally (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (enable),
        .beat_in  (chain[MAX_CLUSTERS]),
        .res_valid(res_valid),
        .res      (res)
    );

    assign push = enable && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
                m_data_reg  <= res;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

endmodule

@@ hdl/nca_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for centroid storage and population counts.
module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/nca_cell.sv @@
// One centroid cell: its centroid components, distance accumulator and a
// three-stage slice of the row. Depends on nca_pkg and nca_ram.
module nca_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic              in_use,
    input  logic [nca_pkg::CL_W-1:0] cell_id,
    input  nca_pkg::nca_beat_t beat_in,
    output nca_pkg::nca_beat_t beat_out
);
    import nca_pkg::*;

    logic [VALUE_BITS-1:0]        cent;
    nca_beat_t                    s1_reg;
    nca_beat_t                    s2_reg;
    nca_beat_t                    out_reg;
    nca_beat_t                    out_next;
    logic [SQ_W-1:0]              sq_reg;
    logic [SQ_W-1:0]              sq_next;
    logic [DIST_W-1:0]            acc_reg;
    logic [DIST_W-1:0]            acc_next;
    logic signed [VALUE_BITS:0]   diff;
    logic signed [2*VALUE_BITS+1:0] prod;
    logic [DIST_W:0]              sum;
    logic [DIST_W-1:0]            acc_upd;
    logic                         hit;
    logic                         load_here;

    assign load_here = beat_in.valid && (beat_in.op == OP_LOAD) && (beat_in.cl == cell_id);

    nca_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MAX_DIM)
    ) u_centroids (
        .clk  (aclk),
        .we   (enable && load_here),
        .waddr(beat_in.el),
        .wdata(beat_in.val),
        .re   (enable),
        .raddr(beat_in.el),
        .rdata(cent)
    );

    always_comb begin
        diff    = {s1_reg.val[VALUE_BITS-1], s1_reg.val}
                - $signed({cent[VALUE_BITS-1], cent});
        prod    = diff * diff;
        sq_next = prod[SQ_W-1:0];
    end

    always_comb begin
        hit      = s2_reg.valid && (s2_reg.op == OP_POINT) && in_use;
        sum      = {1'b0, acc_reg} + (DIST_W+1)'(sq_reg);
        acc_upd  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        acc_next = acc_reg;
        out_next = s2_reg;
        if (hit) begin
            acc_next = s2_reg.last ? '0 : acc_upd;
            // Strictly smaller only, so ties keep the lower cluster index.
            if (s2_reg.last && (acc_upd < s2_reg.best_dist)) begin
                out_next.best_idx  = cell_id;
                out_next.best_dist = acc_upd;
            end
        end else if (s2_reg.valid && (s2_reg.op == OP_POINT) && s2_reg.last) begin
            // A cell outside the search still starts the next point from zero.
            acc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid  <= 1'b0;
            s2_reg.valid  <= 1'b0;
            out_reg.valid <= 1'b0;
            acc_reg       <= '0;
        end else if (enable) begin
            s1_reg  <= beat_in;
            s2_reg  <= s1_reg;
            sq_reg  <= sq_next;
            out_reg <= out_next;
            acc_reg <= acc_next;
        end
    end

    assign beat_out = out_reg;

endmodule

@@ hdl/nca_tally.sv @@
// Tail of the row: population counts, point counter and result assembly.
// Depends on nca_pkg and nca_ram.
module nca_tally (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                enable,
    input  nca_pkg::nca_beat_t  beat_in,
    output logic                res_valid,
    output nca_pkg::nca_result_t res
);
    import nca_pkg::*;

    logic                    take;
    logic [POP_W-1:0]        pop_rdata;
    logic [MAX_CLUSTERS-1:0] pop_vld_reg;
    logic                    t1_valid_reg;
    logic [CL_W-1:0]         t1_idx_reg;
    logic [DIST_W-1:0]       t1_dist_reg;
    logic                    t1_vld_reg;
    logic                    wr_valid_reg;
    logic [CL_W-1:0]         wr_idx_reg;
    logic [POP_W-1:0]        wr_val_reg;
    logic [PN_W-1:0]         pcount_reg;
    logic [POP_W-1:0]        pop_old;
    logic [POP_W-1:0]        pop_new;

    assign take = beat_in.valid && (beat_in.op == OP_POINT) && beat_in.last;

    nca_ram #(
        .WIDTH(POP_W),
        .DEPTH(MAX_CLUSTERS)
    ) u_population (
        .clk  (aclk),
        .we   (enable && t1_valid_reg),
        .waddr(t1_idx_reg),
        .wdata(pop_new),
        .re   (enable),
        .raddr(beat_in.best_idx),
        .rdata(pop_rdata)
    );

    // The count written on the same edge as our read is not in the read data yet.
    always_comb begin
        if (wr_valid_reg && (wr_idx_reg == t1_idx_reg)) begin
            pop_old = wr_val_reg;
        end else if (t1_vld_reg) begin
            pop_old = pop_rdata;
        end else begin
            pop_old = '0;
        end
        pop_new = (pop_old == POP_MAX) ? pop_old : pop_old + POP_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_vld_reg  <= '0;
            t1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            pcount_reg   <= '0;
        end else if (enable) begin
            t1_valid_reg <= take;
            t1_idx_reg   <= beat_in.best_idx;
            t1_dist_reg  <= beat_in.best_dist;
            t1_vld_reg   <= pop_vld_reg[beat_in.best_idx];
            wr_valid_reg <= t1_valid_reg;
            wr_idx_reg   <= t1_idx_reg;
            wr_val_reg   <= pop_new;
            if (t1_valid_reg) begin
                pop_vld_reg[t1_idx_reg] <= 1'b1;
                pcount_reg              <= pcount_reg + PN_W'(1);
            end
        end
    end

    assign res_valid              = t1_valid_reg;
    assign res.best_cluster       = t1_idx_reg;
    assign res.min_distance       = t1_dist_reg;
    assign res.point_number       = pcount_reg;
    assign res.cluster_population = pop_new;

endmodule

@@ hdl/nca_checker.sv @@
// Port-level checks on the nearest-centroid block, bound to its top level.
// Depends on nca_pkg and nearest_centroid_assign_defines.svh.
`include "nearest_centroid_assign_defines.svh"

module nca_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nca_pkg::M_TDATA_W-1:0] m_tdata
);
    import nca_pkg::*;

    logic [PN_W-1:0]  pn_expect_reg;
    logic [PN_W-1:0]  pn_seen;
    logic [POP_W-1:0] pop_seen;

    assign pn_seen  = m_tdata[CL_W+DIST_W +: PN_W];
    assign pop_seen = m_tdata[CL_W+DIST_W+PN_W +: POP_W];

    // Results leave in point order, so each beat carries the next number.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_expect_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            pn_expect_reg <= pn_expect_reg + PN_W'(1);
        end
    end

    `NCA_ASSERT_NXT(a_valid_held, m_tvalid && !m_tready, m_tvalid, "result beat withdrawn")
    `NCA_ASSERT_NXT(a_data_held, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
    `NCA_ASSERT_IMP(a_pn_order, m_tvalid, pn_seen == pn_expect_reg, "point number out of order")
    `NCA_ASSERT_IMP(a_pop_nonzero, m_tvalid, pop_seen != '0, "winner has zero population")
    `NCA_ASSERT_IMP(a_ready_low, !s_tready, m_tvalid, "input stalled with no result waiting")

endmodule

bind nearest_centroid_assign nca_checker u_nca_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
